### rtl/srd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the sampled rank dictionary.
// No dependencies.
package srd_pkg;
   localparam int KeySpace = 4096;
   localparam int KeyW     = 12;
   localparam int CountW   = 13;
   localparam int BsW      = 9;
   localparam int HintW    = 8;
   localparam int BsMax    = 256;
   localparam logic [HintW-1:0] HintCap = 8'd255;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_RANK = 2'd1,
      ACT_NEXT = 2'd2,
      ACT_NONE = 2'd3
   } action_type;
endpackage

### rtl/sampled_rank_dictionary_top.sv
`timescale 1ns / 1ps
// Sampled rank dictionary: membership bitmap with block counts and hints.
// Depends on srd_pkg, srd_ram, srd_div.
//
// Usage: a word is taken on start while busy is low. Action load appends
// one membership bit (no result); final_bit or the bit at position 4095
// ends loading. Rank and next queries end with one rsp_strobe cycle
// carrying the answer and the set summary; the receiver cannot stall.
// A query before loading finished answers at once with not_loaded set.
// Rank and next queries that need a scan raise busy. Rank: divider (key
// by block size), lookup of block count and hint, then a read state and
// a check state per bitmap bit from block start plus hint up to the key.
// Next: a read state and a check state per bitmap bit from key+1 to the
// next member. The single-port read of the bitmap RAM sets the scan speed.
// csr_data sets block_size (0 acts as 1, above 256 as 256); a write is
// only applied before the first load. csr_ready is always high.
// Reset clears load progress and restores block_size 64; the RAMs are not
// cleared, only loaded entries are ever read.
module sampled_rank_dictionary_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_action,
   input  logic [srd_pkg::KeyW-1:0]   req_key,
   input  logic                       req_member_bit,
   input  logic                       req_final_bit,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [srd_pkg::BsW-1:0]    csr_data,
   output logic                       rsp_strobe,
   output logic [srd_pkg::CountW-1:0] rsp_answer,
   output logic                       rsp_no_next,
   output logic                       rsp_not_loaded,
   output logic [srd_pkg::CountW-1:0] rsp_member_total,
   output logic [srd_pkg::KeyW-1:0]   rsp_smallest_member,
   output logic [srd_pkg::KeyW-1:0]   rsp_largest_member,
   output logic                       rsp_set_empty
);
   import srd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_DIV     = 5'b00010,
      S_LOOK    = 5'b00100,
      S_SCAN_RD = 5'b01000,
      S_SCAN_CK = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [BsW-1:0]   bs_ff, bs_in, bs_eff;
   logic [CountW-1:0] pos_ff, pos_in;
   logic [KeyW-1:0]  blk_ff, blk_in;
   logic [BsW-1:0]   off_ff, off_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [HintW-1:0] hint_ff, hint_in, hint_eff;
   logic             seen_ff, seen_in, seen_eff;
   logic [KeyW-1:0]  least_ff, least_in;
   logic [KeyW-1:0]  great_ff, great_in;
   logic             done_ff, done_in;
   logic             rank_ff, rank_in;
   logic [KeyW-1:0]  key_ff, key_in;
   logic [CountW-1:0] t_ff, t_in;
   logic [CountW-1:0] ans_ff, ans_in;

   logic             rsp_v_ff, rsp_v_in;
   logic [CountW-1:0] rsp_ans_ff, rsp_ans_in;
   logic             rsp_nn_ff, rsp_nn_in;
   logic             rsp_nl_ff, rsp_nl_in;
   logic [CountW-1:0] rsp_tot_ff, rsp_tot_in;
   logic [KeyW-1:0]  rsp_min_ff, rsp_min_in;
   logic [KeyW-1:0]  rsp_max_ff, rsp_max_in;
   logic             rsp_emp_ff, rsp_emp_in;

   logic             accept, is_load, empty;
   logic             map_we, cnt_we, hint_we;
   logic [KeyW-1:0]  map_raddr;
   logic [0:0]       map_rdata;
   logic [CountW-1:0] cnt_rdata;
   logic [HintW-1:0] hint_wdata, hint_rdata;
   logic             div_start, div_done;
   logic [KeyW-1:0]  div_quot;
   logic [BsW-1:0]   div_rem;
   logic             fin;
   logic [CountW-1:0] fin_ans;
   logic             fin_nn, fin_nl;

   assign accept    = start && !busy;
   assign is_load   = accept && (req_action == ACT_LOAD) && !done_ff;
   assign empty     = cnt_ff == '0;
   assign csr_ready = 1'b1;
   assign seen_eff  = (off_ff == '0) ? 1'b0 : seen_ff;
   assign hint_eff  = (off_ff == '0) ? '0 : hint_ff;

   always_comb begin
      if (bs_ff == '0) begin
         bs_eff = BsW'(1);
      end else if (bs_ff > BsW'(BsMax)) begin
         bs_eff = BsW'(BsMax);
      end else begin
         bs_eff = bs_ff;
      end
   end

   // load bookkeeping and block_size writes
   always_comb begin
      bs_in    = bs_ff;
      pos_in   = pos_ff;
      blk_in   = blk_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      hint_in  = hint_ff;
      seen_in  = seen_ff;
      least_in = least_ff;
      great_in = great_ff;
      done_in  = done_ff;
      map_we   = 1'b0;
      cnt_we   = 1'b0;
      hint_we  = 1'b0;
      hint_wdata = hint_eff;
      if (csr_valid && csr_ready && pos_ff == '0) begin
         bs_in = csr_data;
      end
      if (is_load) begin
         map_we  = 1'b1;
         cnt_we  = off_ff == '0;
         hint_in = hint_eff;
         seen_in = seen_eff;
         if (req_member_bit) begin
            if (cnt_ff == '0) begin
               least_in = pos_ff[KeyW-1:0];
            end
            cnt_in   = cnt_ff + 1'b1;
            great_in = pos_ff[KeyW-1:0];
            hint_we  = 1'b1;
            seen_in  = 1'b1;
         end else if (!seen_eff) begin
            if (hint_eff < HintCap) begin
               hint_in = hint_eff + 1'b1;
            end
            hint_we    = 1'b1;
            hint_wdata = hint_in;
         end
         pos_in = pos_ff + 1'b1;
         if ({1'b0, off_ff} + 10'd1 == {1'b0, bs_eff}) begin
            off_in = '0;
            blk_in = blk_ff + 1'b1;
         end else begin
            off_in = off_ff + 1'b1;
         end
         if (req_final_bit || pos_ff == CountW'(KeySpace - 1)) begin
            done_in = 1'b1;
         end
      end
   end

   // query sequencer
   always_comb begin
      state_in  = state_ff;
      rank_in   = rank_ff;
      key_in    = key_ff;
      t_in      = t_ff;
      ans_in    = ans_ff;
      div_start = 1'b0;
      map_raddr = t_ff[KeyW-1:0];
      fin       = 1'b0;
      fin_ans   = '0;
      fin_nn    = 1'b0;
      fin_nl    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACT_RANK || req_action == ACT_NEXT)) begin
               rank_in = req_action == ACT_RANK;
               key_in  = req_key;
               if (!done_ff) begin
                  fin    = 1'b1;
                  fin_nl = 1'b1;
               end else if (req_action == ACT_RANK) begin
                  if (empty || req_key > great_ff) begin
                     fin     = 1'b1;
                     fin_ans = cnt_ff;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end else begin
                  if (empty || req_key >= great_ff) begin
                     fin    = 1'b1;
                     fin_nn = 1'b1;
                  end else begin
                     t_in     = {1'b0, req_key} + 1'b1;
                     ans_in   = '0;
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               t_in     = {1'b0, key_ff} - {4'd0, div_rem};
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            ans_in   = cnt_rdata;
            t_in     = t_ff + {5'd0, hint_rdata};
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (rank_ff && t_ff >= {1'b0, key_ff}) begin
               fin      = 1'b1;
               fin_ans  = ans_ff;
               state_in = S_IDLE;
            end else if (!rank_ff && t_ff > {1'b0, great_ff}) begin
               fin      = 1'b1;
               fin_nn   = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            if (rank_ff) begin
               ans_in   = ans_ff + {12'd0, map_rdata};
               t_in     = t_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else if (map_rdata[0]) begin
               fin      = 1'b1;
               fin_ans  = t_ff;
               state_in = S_IDLE;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_v_in   = fin;
      rsp_ans_in = fin_ans;
      rsp_nn_in  = fin_nn;
      rsp_nl_in  = fin_nl;
      rsp_tot_in = fin_nl ? '0 : cnt_ff;
      rsp_min_in = (fin_nl || empty) ? '0 : least_ff;
      rsp_max_in = (fin_nl || empty) ? '0 : great_ff;
      rsp_emp_in = !fin_nl && empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bs_ff    <= BsW'(64);
         pos_ff   <= '0;
         blk_ff   <= '0;
         off_ff   <= '0;
         cnt_ff   <= '0;
         hint_ff  <= '0;
         seen_ff  <= 1'b0;
         least_ff <= '0;
         great_ff <= '0;
         done_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bs_ff    <= bs_in;
         pos_ff   <= pos_in;
         blk_ff   <= blk_in;
         off_ff   <= off_in;
         cnt_ff   <= cnt_in;
         hint_ff  <= hint_in;
         seen_ff  <= seen_in;
         least_ff <= least_in;
         great_ff <= great_in;
         done_ff  <= done_in;
         rsp_v_ff <= rsp_v_in;
      end
      rank_ff    <= rank_in;
      key_ff     <= key_in;
      t_ff       <= t_in;
      ans_ff     <= ans_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_nn_ff  <= rsp_nn_in;
      rsp_nl_ff  <= rsp_nl_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in;
      rsp_emp_ff <= rsp_emp_in;
   end

   srd_ram #(.WIDTH(1), .DEPTH(KeySpace)) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (pos_ff[KeyW-1:0]),
      .wdata (req_member_bit),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   srd_ram #(.WIDTH(CountW), .DEPTH(KeySpace)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (blk_ff),
      .wdata (cnt_ff),
      .raddr (div_quot),
      .rdata (cnt_rdata)
   );

   srd_ram #(.WIDTH(HintW), .DEPTH(KeySpace)) u_hints (
      .clock (clock),
      .we    (hint_we),
      .waddr (blk_ff),
      .wdata (hint_wdata),
      .raddr (div_quot),
      .rdata (hint_rdata)
   );

   srd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_key),
      .divisor  (bs_eff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign busy                = state_ff != S_IDLE;
   assign rsp_strobe          = rsp_v_ff;
   assign rsp_answer          = rsp_ans_ff;
   assign rsp_no_next         = rsp_nn_ff;
   assign rsp_not_loaded      = rsp_nl_ff;
   assign rsp_member_total    = rsp_tot_ff;
   assign rsp_smallest_member = rsp_min_ff;
   assign rsp_largest_member  = rsp_max_ff;
   assign rsp_set_empty       = rsp_emp_ff;

   a_ck_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_CK |-> $past(state_ff) == S_SCAN_RD)
      else $error("bit check without read");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("load done dropped");

   a_nl_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_nl_ff |-> rsp_ans_ff == '0 && !rsp_nn_ff)
      else $error("not-loaded word carries data");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(pos_ff))
      else $error("load during query");
endmodule

### rtl/srd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/srd_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider: key by block size, one quotient bit per cycle.
// Depends on srd_pkg.
module srd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [srd_pkg::KeyW-1:0]    dividend,
   input  logic [srd_pkg::BsW-1:0]     divisor,
   output logic                        done,
   output logic [srd_pkg::KeyW-1:0]    quot,
   output logic [srd_pkg::BsW-1:0]     rem
);
   import srd_pkg::*;

   localparam int CntW = $clog2(KeyW + 1);

   logic [KeyW-1:0] quo_ff, quo_in;
   logic [BsW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [BsW:0]    shifted;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[KeyW-1]};
      fits    = shifted >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CntW'(KeyW);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[KeyW-2:0], fits};
         rem_in = fits ? BsW'(shifted - {1'b0, divisor}) : BsW'(shifted);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule

### tb/sv/sampled_rank_dictionary_checker.sv
`timescale 1ns / 1ps
// Checker for the sampled rank dictionary: watches the request, csr and
// response channels, predicts each response and compares it. Uses srd_pkg.
module sampled_rank_dictionary_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_action,
   input  logic [srd_pkg::KeyW-1:0]   req_key,
   input  logic                       req_member_bit,
   input  logic                       req_final_bit,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [srd_pkg::BsW-1:0]    csr_data,
   input  logic                       rsp_strobe,
   input  logic [srd_pkg::CountW-1:0] rsp_answer,
   input  logic                       rsp_no_next,
   input  logic                       rsp_not_loaded,
   input  logic [srd_pkg::CountW-1:0] rsp_member_total,
   input  logic [srd_pkg::KeyW-1:0]   rsp_smallest_member,
   input  logic [srd_pkg::KeyW-1:0]   rsp_largest_member,
   input  logic                       rsp_set_empty,
   output int                         fail_count,
   output int                         pending
);
   import srd_pkg::*;

   typedef struct packed {
      logic [CountW-1:0] answer;
      logic              no_next;
      logic              not_loaded;
      logic [CountW-1:0] member_total;
      logic [KeyW-1:0]   smallest_member;
      logic [KeyW-1:0]   largest_member;
      logic              set_empty;
   } answer_word_type;

   logic              member_map [KeySpace];
   logic [CountW-1:0] block_count [KeySpace];
   logic [HintW-1:0]  block_hint [KeySpace];
   logic [CountW-1:0] load_pos;
   logic [CountW-1:0] member_count;
   logic [HintW-1:0]  lead_gap;
   logic              member_seen;
   logic [KeyW-1:0]   least_key;
   logic [KeyW-1:0]   greatest_key;
   logic              loaded;
   logic [BsW-1:0]    block_size;
   answer_word_type   answers_due [$];
   int                fail_total = 0;

   function automatic int eff_block();
      if (block_size == 0) return 1;
      if (block_size > BsMax) return BsMax;
      return block_size;
   endfunction

   task automatic append_bit(input logic b, input logic fin);
      int k, bs, blk;
      if (loaded || load_pos >= KeySpace) return;
      k = load_pos;
      bs = eff_block();
      blk = k / bs;
      if (k % bs == 0) begin
         block_count[blk] = member_count;
         lead_gap = '0;
         member_seen = 1'b0;
      end
      member_map[k] = b;
      if (b) begin
         if (member_count == 0) least_key = KeyW'(k);
         member_count = member_count + 1'b1;
         greatest_key = KeyW'(k);
         block_hint[blk] = lead_gap;
         member_seen = 1'b1;
      end else if (!member_seen) begin
         if (lead_gap < HintCap) lead_gap = lead_gap + 1'b1;
         block_hint[blk] = lead_gap;
      end
      load_pos = load_pos + 1'b1;
      if (fin || load_pos >= KeySpace) loaded = 1'b1;
   endtask

   function automatic answer_word_type lookup(input logic [1:0] act, input int key);
      answer_word_type w;
      int bs, blk, t;
      logic empty;
      w = '0;
      if (!loaded) begin
         w.not_loaded = 1'b1;
         return w;
      end
      empty = (member_count == 0);
      if (act == ACT_RANK) begin
         if (empty || key > greatest_key) begin
            w.answer = member_count;
         end else begin
            bs = eff_block();
            blk = key / bs;
            w.answer = block_count[blk];
            for (t = blk * bs + block_hint[blk]; t < key; t++)
               if (member_map[t]) w.answer = w.answer + 1'b1;
         end
      end else begin
         w.no_next = 1'b1;
         if (!empty && key < greatest_key) begin
            for (t = key + 1; t <= greatest_key; t++) begin
               if (member_map[t]) begin
                  w.answer = CountW'(t);
                  w.no_next = 1'b0;
                  break;
               end
            end
         end
      end
      w.member_total = member_count;
      w.smallest_member = empty ? '0 : least_key;
      w.largest_member = empty ? '0 : greatest_key;
      w.set_empty = empty;
      return w;
   endfunction

   assign pending = answers_due.size();
   assign fail_count = fail_total;

   always @(posedge clock) begin
      answer_word_type got, want;
      if (reset) begin
         load_pos = '0;
         member_count = '0;
         lead_gap = '0;
         member_seen = 1'b0;
         least_key = '0;
         greatest_key = '0;
         loaded = 1'b0;
         block_size = 9'd64;
         answers_due.delete();
      end else begin
         if (csr_valid && csr_ready && load_pos == 0) block_size = csr_data;
         if (start && !busy) begin
            if (req_action == ACT_LOAD) append_bit(req_member_bit, req_final_bit);
            else if (req_action != ACT_NONE)
               answers_due.push_back(lookup(req_action, req_key));
         end
         if (rsp_strobe) begin
            got = '{rsp_answer, rsp_no_next, rsp_not_loaded, rsp_member_total,
                    rsp_smallest_member, rsp_largest_member, rsp_set_empty};
            if (answers_due.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) $display("unexpected response word %p", got);
            end else begin
               want = answers_due.pop_front();
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("response mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end
endmodule

### tb/sv/sampled_rank_dictionary_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for sampled_rank_dictionary_top: drives loads, queries and
// csr words and gives the verdict. Uses srd_pkg and the checker module.
module sampled_rank_dictionary_top_tb;
   import srd_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = ACT_NONE;
   logic [KeyW-1:0]   req_key = '0;
   logic              req_member_bit = 1'b0;
   logic              req_final_bit = 1'b0;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [BsW-1:0]    csr_data = '0;
   logic              rsp_strobe;
   logic [CountW-1:0] rsp_answer;
   logic              rsp_no_next;
   logic              rsp_not_loaded;
   logic [CountW-1:0] rsp_member_total;
   logic [KeyW-1:0]   rsp_smallest_member;
   logic [KeyW-1:0]   rsp_largest_member;
   logic              rsp_set_empty;
   int                fail_count;
   int                pending;
   int                idle_cycles = 0;
   int                no_gap_run = 0;
   int                load_len, first_member, last_member;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sampled_rank_dictionary_top dut (.*);
   sampled_rank_dictionary_checker chk (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("sampled_rank_dictionary_top: mismatch");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] act, input int key,
                            input logic mb, input logic fb);
      int gap;
      if (no_gap_run > 0) begin
         gap = 0;
         no_gap_run--;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 30) == 0) no_gap_run = $urandom_range(5, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_key <= KeyW'(key);
      req_member_bit <= mb;
      req_final_bit <= fb;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic write_block_size(input int value);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= BsW'(value);
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_key();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return KeySpace - 1;
         2: return last_member;
         3: return first_member;
         4, 5, 6: return $urandom_range(0, load_len - 1);
         7: return $urandom_range(last_member > 3 ? last_member - 3 : 0,
                                  last_member + 3 < KeySpace ? last_member + 3 : KeySpace - 1);
         default: return $urandom_range(0, KeySpace - 1);
      endcase
   endfunction

   initial begin
      int density, seg_left, queries, k, r, bs;
      logic mb;
      int sizes [8] = '{1, 2, 64, 255, 256, 0, 511, 300};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_block_size(0);
      write_block_size(511);
      send_word(ACT_RANK, 0, 1'b0, 1'b0);
      send_word(ACT_NEXT, KeySpace - 1, 1'b1, 1'b1);
      send_word(ACT_NONE, 1234, 1'b1, 1'b0);
      drain();
      bs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : sizes[$urandom_range(0, 7)];
      write_block_size(bs);

      load_len = $urandom_range(200, 1500);
      first_member = 0;
      last_member = 0;
      seg_left = 0;
      density = 8;
      for (k = 0; k < load_len; k++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 300);
            case ($urandom_range(0, 7))
               0: density = 0;
               1: density = 1;
               2: density = 15;
               3: density = 16;
               default: density = $urandom_range(2, 12);
            endcase
         end
         seg_left--;
         mb = ($urandom_range(0, 15) < density);
         if (mb && last_member == 0 && first_member == 0) first_member = k;
         if (mb) last_member = k;
         send_word(ACT_LOAD, $urandom_range(0, KeySpace - 1), mb, k == load_len - 1);
         r = $urandom_range(0, 19);
         if (r == 0)
            send_word($urandom_range(0, 1) ? ACT_NEXT : ACT_RANK,
                      $urandom_range(0, KeySpace - 1),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else if (r == 1)
            send_word(ACT_NONE, $urandom_range(0, KeySpace - 1), 1'b1, 1'b1);
      end

      send_word(ACT_RANK, 0, 1'b0, 1'b0);
      send_word(ACT_RANK, KeySpace - 1, 1'b1, 1'b1);
      send_word(ACT_NEXT, 0, 1'b0, 1'b1);
      send_word(ACT_NEXT, KeySpace - 1, 1'b1, 1'b0);
      send_word(ACT_RANK, last_member, 1'b0, 1'b0);
      send_word(ACT_NEXT, last_member, 1'b0, 1'b0);
      send_word(ACT_NEXT, first_member, 1'b0, 1'b0);
      send_word(ACT_LOAD, 0, 1'b1, 1'b1);
      send_word(ACT_NONE, 0, 1'b0, 1'b0);
      drain();
      write_block_size(256);
      write_block_size(1);

      queries = (1650 - load_len > 300) ? 1650 - load_len : 300;
      while (queries > 0) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_word(ACT_LOAD, pick_key(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else if (r < 8) begin
            send_word(ACT_NONE, pick_key(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_word(r < 54 ? ACT_RANK : ACT_NEXT, pick_key(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            queries--;
         end
      end
      drain();
      if (fail_count == 0)
         $display("sampled_rank_dictionary_top: match");
      else
         $display("sampled_rank_dictionary_top: mismatch");
      $finish;
   end
endmodule
